// ===== rtl/tbrs_pkg.sv =====
package tbrs_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_PERIOD       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_PERIOD     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_PERIOD       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLASH_THRESHOLD   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_SCANS  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BACKLIGHT_SECONDS = 3'd5;

    // Field widths
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned SEC_W      = 7;
    localparam int unsigned SCAN_W     = 4;
    localparam int unsigned HOLD_W     = 10;
    localparam int unsigned BL_W       = 8;

    // Register reset values
    localparam logic [PCT_W-1:0]  RST_RAMP_PERIOD       = 7'd120;
    localparam logic [SEC_W-1:0]  RST_SECOND_PERIOD     = 7'd99;
    localparam logic [SCAN_W-1:0] RST_SCAN_PERIOD       = 4'd9;
    localparam logic [SEC_W-1:0]  RST_FLASH_THRESHOLD   = 7'd50;
    localparam logic [HOLD_W-1:0] RST_LONG_PRESS_SCANS  = 10'd100;
    localparam logic [BL_W-1:0]   RST_BACKLIGHT_SECONDS = 8'd10;

    // One result beat
    typedef struct packed {
        logic [PCT_W-1:0] brightness;
        logic             brightness_changed;
        logic             second_pulse;
        logic             flash_level;
        logic             scan_pulse;
        logic             press0_pulse;
        logic             long0_level;
        logic             press1_pulse;
        logic             long1_level;
        logic [BL_W-1:0]  backlight_remaining;
    } t_result;

endpackage

// ===== rtl/tick_button_ramp_scheduler.sv =====
// An accepted tick's result beat is registered and shows on the output register in the cycle after.
// Throughput: one tick per cycle; the output register accepts a new tick in the same
// cycle its held beat is taken, so the rate is set by the downstream ready alone.
// Reset (synchronous, active low): dividers, brightness, backlight, hold and long
// state clear, both buttons read as released, registers load their default values.
module tick_button_ramp_scheduler
    import tbrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_button0_level,
    input  logic                  i_button1_level,
    input  logic [PCT_W-1:0]      i_target_percent,
    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PCT_W-1:0]      o_brightness,
    output logic                  o_brightness_changed,
    output logic                  o_second_pulse,
    output logic                  o_flash_level,
    output logic                  o_scan_pulse,
    output logic                  o_press0_pulse,
    output logic                  o_long0_level,
    output logic                  o_press1_pulse,
    output logic                  o_long1_level,
    output logic [BL_W-1:0]       o_backlight_remaining
);

    // Configuration registers
    logic [PCT_W-1:0]  r_ramp_period;
    logic [SEC_W-1:0]  r_second_period;
    logic [SCAN_W-1:0] r_scan_period;
    logic [SEC_W-1:0]  r_flash_threshold;
    logic [HOLD_W-1:0] r_long_press_scans;
    logic [BL_W-1:0]   r_backlight_seconds;

    // Block state
    logic [PCT_W-1:0]  r_ramp_count,   n_ramp_count;
    logic [SEC_W-1:0]  r_second_count, n_second_count;
    logic [SCAN_W-1:0] r_scan_count,   n_scan_count;
    logic [PCT_W-1:0]  r_level,        n_level;
    logic [BL_W-1:0]   r_backlight,    n_backlight;
    logic              r_prev0,        n_prev0;
    logic              r_prev1,        n_prev1;
    logic [HOLD_W-1:0] r_hold0,        n_hold0;
    logic [HOLD_W-1:0] r_hold1,        n_hold1;
    logic              r_long0,        n_long0;
    logic              r_long1,        n_long1;

    // Output register
    logic              r_out_valid;
    t_result           r_out,          n_out;

    logic              accept;
    logic [PCT_W:0]    ramp_inc;
    logic [SEC_W:0]    second_inc;
    logic [SCAN_W:0]   scan_inc;
    logic              ramp_fire;
    logic              second_fire;
    logic              scan_fire;
    logic              changed;
    logic              press0;
    logic              press1;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_period       <= RST_RAMP_PERIOD;
            r_second_period     <= RST_SECOND_PERIOD;
            r_scan_period       <= RST_SCAN_PERIOD;
            r_flash_threshold   <= RST_FLASH_THRESHOLD;
            r_long_press_scans  <= RST_LONG_PRESS_SCANS;
            r_backlight_seconds <= RST_BACKLIGHT_SECONDS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_RAMP_PERIOD:       r_ramp_period       <= i_cfg_wdata[PCT_W-1:0];
                CFG_SECOND_PERIOD:     r_second_period     <= i_cfg_wdata[SEC_W-1:0];
                CFG_SCAN_PERIOD:       r_scan_period       <= i_cfg_wdata[SCAN_W-1:0];
                CFG_FLASH_THRESHOLD:   r_flash_threshold   <= i_cfg_wdata[SEC_W-1:0];
                CFG_LONG_PRESS_SCANS:  r_long_press_scans  <= i_cfg_wdata[HOLD_W-1:0];
                CFG_BACKLIGHT_SECONDS: r_backlight_seconds <= i_cfg_wdata[BL_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the three dividers; a count whose increment reaches or passes the period wraps to zero
    always_comb begin
        ramp_inc    = {1'b0, r_ramp_count} + 1'b1;
        second_inc  = {1'b0, r_second_count} + 1'b1;
        scan_inc    = {1'b0, r_scan_count} + 1'b1;
        ramp_fire   = ramp_inc >= {1'b0, r_ramp_period};
        second_fire = second_inc >= {1'b0, r_second_period};
        scan_fire   = scan_inc >= {1'b0, r_scan_period};
        n_ramp_count   = ramp_fire   ? '0 : ramp_inc[PCT_W-1:0];
        n_second_count = second_fire ? '0 : second_inc[SEC_W-1:0];
        n_scan_count   = scan_fire   ? '0 : scan_inc[SCAN_W-1:0];
    end

    // Step brightness one percent toward the target on a ramp event
    always_comb begin
        n_level = r_level;
        changed = 1'b0;
        if (ramp_fire) begin
            if (r_level < i_target_percent) begin
                n_level = r_level + 1'b1;
                changed = 1'b1;
            end else if (r_level > i_target_percent) begin
                n_level = r_level - 1'b1;
                changed = 1'b1;
            end
        end
    end

    // Count the backlight down on a second event, then scan both buttons
    always_comb begin
        n_backlight = r_backlight;
        if (second_fire && r_backlight != '0) begin
            n_backlight = r_backlight - 1'b1;
        end

        n_prev0 = r_prev0;
        n_hold0 = r_hold0;
        n_long0 = r_long0;
        press0  = 1'b0;
        n_prev1 = r_prev1;
        n_hold1 = r_hold1;
        n_long1 = r_long1;
        press1  = 1'b0;

        if (scan_fire) begin
            // button 0
            if (!i_button0_level && r_prev0) begin
                press0      = 1'b1;
                n_prev0     = 1'b0;
                n_hold0     = r_long_press_scans;
                n_backlight = r_backlight_seconds;
            end else if (!i_button0_level) begin
                if (r_hold0 != '0) begin
                    n_hold0 = r_hold0 - 1'b1;
                end
                if (r_hold0 <= HOLD_W'(1)) begin
                    n_long0 = 1'b1;
                end
                n_backlight = r_backlight_seconds;
            end else if (!r_prev0) begin
                n_long0 = 1'b0;
                n_hold0 = '0;
                n_prev0 = 1'b1;
            end

            // button 1
            if (!i_button1_level && r_prev1) begin
                press1      = 1'b1;
                n_prev1     = 1'b0;
                n_hold1     = r_long_press_scans;
                n_backlight = r_backlight_seconds;
            end else if (!i_button1_level) begin
                if (r_hold1 != '0) begin
                    n_hold1 = r_hold1 - 1'b1;
                end
                if (r_hold1 <= HOLD_W'(1)) begin
                    n_long1 = 1'b1;
                end
                n_backlight = r_backlight_seconds;
            end else if (!r_prev1) begin
                n_long1 = 1'b0;
                n_hold1 = '0;
                n_prev1 = 1'b1;
            end
        end
    end

    // Assemble the result beat from the updated state
    always_comb begin
        n_out.brightness          = n_level;
        n_out.brightness_changed  = changed;
        n_out.second_pulse        = second_fire;
        n_out.flash_level         = n_second_count >= r_flash_threshold;
        n_out.scan_pulse          = scan_fire;
        n_out.press0_pulse        = press0;
        n_out.long0_level         = n_long0;
        n_out.press1_pulse        = press1;
        n_out.long1_level         = n_long1;
        n_out.backlight_remaining = n_backlight;
    end

    // Commit state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_count   <= '0;
            r_second_count <= '0;
            r_scan_count   <= '0;
            r_level        <= '0;
            r_backlight    <= '0;
            r_prev0        <= 1'b1;
            r_prev1        <= 1'b1;
            r_hold0        <= '0;
            r_hold1        <= '0;
            r_long0        <= 1'b0;
            r_long1        <= 1'b0;
        end else if (accept) begin
            r_ramp_count   <= n_ramp_count;
            r_second_count <= n_second_count;
            r_scan_count   <= n_scan_count;
            r_level        <= n_level;
            r_backlight    <= n_backlight;
            r_prev0        <= n_prev0;
            r_prev1        <= n_prev1;
            r_hold0        <= n_hold0;
            r_hold1        <= n_hold1;
            r_long0        <= n_long0;
            r_long1        <= n_long1;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_brightness          = r_out.brightness;
    assign o_brightness_changed  = r_out.brightness_changed;
    assign o_second_pulse        = r_out.second_pulse;
    assign o_flash_level         = r_out.flash_level;
    assign o_scan_pulse          = r_out.scan_pulse;
    assign o_press0_pulse        = r_out.press0_pulse;
    assign o_long0_level         = r_out.long0_level;
    assign o_press1_pulse        = r_out.press1_pulse;
    assign o_long1_level         = r_out.long1_level;
    assign o_backlight_remaining = r_out.backlight_remaining;

endmodule

// ===== verif/tb_tick_button_ramp_scheduler.sv =====
module tb_tick_button_ramp_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import tbrs_pkg::*;

    // Register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_button0_level = 1'b1;
    logic                  i_button1_level = 1'b1;
    logic [PCT_W-1:0]      i_target_percent = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [PCT_W-1:0]      o_brightness;
    logic                  o_brightness_changed;
    logic                  o_second_pulse;
    logic                  o_flash_level;
    logic                  o_scan_pulse;
    logic                  o_press0_pulse;
    logic                  o_long0_level;
    logic                  o_press1_pulse;
    logic                  o_long1_level;
    logic [BL_W-1:0]       o_backlight_remaining;

    tick_button_ramp_scheduler dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_button0_level       (i_button0_level),
        .i_button1_level       (i_button1_level),
        .i_target_percent      (i_target_percent),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_brightness          (o_brightness),
        .o_brightness_changed  (o_brightness_changed),
        .o_second_pulse        (o_second_pulse),
        .o_flash_level         (o_flash_level),
        .o_scan_pulse          (o_scan_pulse),
        .o_press0_pulse        (o_press0_pulse),
        .o_long0_level         (o_long0_level),
        .o_press1_pulse        (o_press1_pulse),
        .o_long1_level         (o_long1_level),
        .o_backlight_remaining (o_backlight_remaining)
    );

    // Scheduler registers as the predictor sees them
    bit [6:0] cfg_ramp, cfg_sec, cfg_flash;
    bit [3:0] cfg_scan;
    bit [9:0] cfg_long;
    bit [7:0] cfg_bl;

    // Predicted scheduler state
    bit [6:0] ramp_div, sec_div, scan_div, lvl;
    bit [7:0] bl_left;
    bit       btn_prev [2];
    bit [9:0] btn_hold [2];
    bit       btn_long [2];

    // Pending result beats, oldest first
    t_result  tick_results_q [$];
    t_result  head_exp;

    // Stimulus state for button runs and target drift
    bit [1:0] stim_pin = 2'b11;
    int       run_left [2];
    bit [6:0] stim_tgt;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_cycles = 0;

    int errors = 0;
    int cycle_cnt = 0;
    int ticks_sent = 0;
    int beats_checked = 0;
    int cfg_writes = 0;
    int press_pulses = 0;
    int long_ticks = 0;

    initial forever #2 i_clk = ~i_clk;

    // Advance a tick divider; returns 1 when its period ends
    function automatic bit div_step(inout bit [6:0] cnt, input bit [6:0] period);
        if (int'(cnt) + 1 >= int'(period)) begin
            cnt = '0;
            return 1'b1;
        end
        cnt = cnt + 7'd1;
        return 1'b0;
    endfunction

    // Apply one tick to the predicted state and return its result beat
    function automatic t_result advance_scheduler(bit b0, bit b1, bit [6:0] tgt);
        t_result  r;
        bit [1:0] pins;
        bit [1:0] press;
        r = '0;
        pins = {b1, b0};
        press = '0;
        if (div_step(ramp_div, cfg_ramp)) begin
            if (lvl < tgt) begin
                lvl = lvl + 7'd1;
                r.brightness_changed = 1'b1;
            end else if (lvl > tgt) begin
                lvl = lvl - 7'd1;
                r.brightness_changed = 1'b1;
            end
        end
        // Second event counts the backlight down before any scan reload
        if (div_step(sec_div, cfg_sec)) begin
            r.second_pulse = 1'b1;
            if (bl_left != 0) bl_left = bl_left - 8'd1;
        end
        r.flash_level = (sec_div >= cfg_flash);
        if (div_step(scan_div, 7'(cfg_scan))) begin
            r.scan_pulse = 1'b1;
            for (int i = 0; i < 2; i++) begin
                if (!pins[i] && btn_prev[i]) begin
                    press[i] = 1'b1;
                    btn_prev[i] = 1'b0;
                    btn_hold[i] = cfg_long;
                    bl_left = cfg_bl;
                end else if (!pins[i]) begin
                    if (btn_hold[i] != 0) btn_hold[i] = btn_hold[i] - 10'd1;
                    if (btn_hold[i] == 0) btn_long[i] = 1'b1;
                    bl_left = cfg_bl;
                end else if (!btn_prev[i]) begin
                    btn_long[i] = 1'b0;
                    btn_hold[i] = '0;
                    btn_prev[i] = 1'b1;
                end
            end
        end
        r.brightness = lvl;
        r.press0_pulse = press[0];
        r.press1_pulse = press[1];
        r.long0_level = btn_long[0];
        r.long1_level = btn_long[1];
        r.backlight_remaining = bl_left;
        return r;
    endfunction

    function automatic void apply_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_RAMP_PERIOD:       cfg_ramp = data[6:0];
            CFG_SECOND_PERIOD:     cfg_sec = data[6:0];
            CFG_SCAN_PERIOD:       cfg_scan = data[3:0];
            CFG_FLASH_THRESHOLD:   cfg_flash = data[6:0];
            CFG_LONG_PRESS_SCANS:  cfg_long = data[9:0];
            CFG_BACKLIGHT_SECONDS: cfg_bl = data[7:0];
            default: ;
        endcase
    endfunction

    // Mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offer one tick, hold it until accepted, then queue its predicted beat
    task automatic send_tick(bit b0, bit b1, bit [6:0] tgt);
        t_result r;
        int      g;
        i_valid <= 1'b1;
        i_button0_level <= b0;
        i_button1_level <= b1;
        i_target_percent <= tgt;
        do @(posedge i_clk); while (!o_ready);
        r = advance_scheduler(b0, b1, tgt);
        tick_results_q.push_back(r);
        ticks_sent++;
        press_pulses += int'(r.press0_pulse) + int'(r.press1_pulse);
        long_ticks += int'(r.long0_level | r.long1_level);
        g = tx_idle ? pick_gap() : 0;
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every pending beat
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_cfg(addr, data);
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [9:0] ramp, logic [9:0] sec, logic [9:0] scan,
                             logic [9:0] flash, logic [9:0] hold, logic [9:0] bl);
        cfg_write(CFG_RAMP_PERIOD, ramp);
        cfg_write(CFG_SECOND_PERIOD, sec);
        cfg_write(CFG_SCAN_PERIOD, scan);
        cfg_write(CFG_FLASH_THRESHOLD, flash);
        cfg_write(CFG_LONG_PRESS_SCANS, hold);
        cfg_write(CFG_BACKLIGHT_SECONDS, bl);
    endtask

    // Button runs of capped length that may reach long press, target drift, some noise
    task automatic run_ticks(int n);
        bit [1:0] pins;
        int       lim;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 2; i++) begin
                if (run_left[i] == 0) begin
                    stim_pin[i] = ~stim_pin[i];
                    if (!stim_pin[i]) begin
                        lim = (int'(cfg_scan) + 1) * (int'(cfg_long) + 3);
                        if (lim > 300) lim = 300;
                        run_left[i] = $urandom_range(1, lim);
                    end else begin
                        run_left[i] = $urandom_range(1, 3 * (int'(cfg_scan) + 1));
                    end
                end
                run_left[i]--;
            end
            pins = stim_pin;
            if ($urandom_range(0, 19) == 0) pins = 2'($urandom);
            if ($urandom_range(0, 29) == 0) begin
                stim_tgt = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                       : 7'($urandom_range(0, 100));
            end
            send_tick(pins[0], pins[1], stim_tgt);
        end
    endtask

    // Default registers straight out of reset
    task automatic test_reset_defaults();
        stim_tgt = 7'd100;
        run_ticks(130);
        wait_results_done();
    endtask

    // Zero periods, zero long press, zero threshold, target extremes, both buttons
    task automatic test_zero_periods();
        write_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd255);
        send_tick(1'b1, 1'b1, 7'd127);
        send_tick(1'b0, 1'b1, 7'd127);
        send_tick(1'b0, 1'b1, 7'd127);
        send_tick(1'b0, 1'b0, 7'd0);
        send_tick(1'b0, 1'b0, 7'd0);
        send_tick(1'b1, 1'b0, 7'd100);
        send_tick(1'b1, 1'b1, 7'd100);
        send_tick(1'b1, 1'b1, 7'd0);
        wait_results_done();
        // Backlight runs down to zero and stays there
        cfg_write(CFG_BACKLIGHT_SECONDS, 10'd2);
        send_tick(1'b0, 1'b1, 7'd0);
        send_tick(1'b1, 1'b1, 7'd0);
        send_tick(1'b1, 1'b1, 7'd0);
        send_tick(1'b1, 1'b1, 7'd0);
        wait_results_done();
    endtask

    // Lower the periods below the running counters; next tick must fire
    task automatic test_period_lowered();
        write_all(10'd127, 10'd127, 10'd15, 10'd127, 10'd3, 10'd0);
        repeat (6) send_tick(1'b1, 1'b1, 7'd50);
        wait_results_done();
        cfg_write(CFG_RAMP_PERIOD, 10'd2);
        cfg_write(CFG_SECOND_PERIOD, 10'd3);
        cfg_write(CFG_SCAN_PERIOD, 10'd1);
        repeat (4) send_tick(1'b0, 1'b1, 7'd50);
        wait_results_done();
    endtask

    // All-ones writes get truncated; spare indexes change nothing
    task automatic test_register_masking();
        write_all(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
        cfg_write(CFG_SPARE_LO, 10'd0);
        cfg_write(CFG_SPARE_HI, 10'd0);
        send_tick(1'b0, 1'b0, 7'd127);
        send_tick(1'b0, 1'b1, 7'd0);
        send_tick(1'b1, 1'b0, 7'd64);
        send_tick(1'b1, 1'b1, 7'd27);
        wait_results_done();
    endtask

    // Receiver holds off while ticks keep coming, then the sender waits it out
    task automatic test_backpressure();
        write_all(10'd3, 10'd7, 10'd2, 10'd4, 10'd5, 10'd20);
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold_cycles = LONG_HOLD;
        run_ticks(30);
        wait_results_done();
        tx_idle = 1'b1;
        run_ticks(30);
        wait_results_done();
    endtask

    // Several register settings, extremes first, with and without idling
    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_all(10'd1, 10'd1, 10'd1, 10'd0, 10'd0, 10'd0);
                1: write_all(10'd127, 10'd127, 10'd15, 10'd127, 10'd1023, 10'd255);
                default: write_all(10'($urandom_range(0, 20)), 10'($urandom_range(0, 40)),
                                   10'($urandom_range(0, 15)), 10'($urandom_range(0, 40)),
                                   10'($urandom_range(0, 12)), 10'($urandom_range(0, 255)));
            endcase
            tx_idle = (p % 3 != 2);
            rx_idle = (p % 3 != 2);
            run_ticks(105);
            wait_results_done();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        int hold_n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                hold_n = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_ready <= 1'b0;
                repeat (hold_n) @(posedge i_clk);
            end else if (rx_idle && $urandom_range(0, 2) == 0) begin
                g = pick_gap();
                if (g != 0) begin
                    i_ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each accepted beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (tick_results_q.size() == 0) begin
                $error("result beat with no tick pending");
                errors++;
            end else begin
                head_exp = tick_results_q.pop_front();
                check_field("brightness", 8'(head_exp.brightness), 8'(o_brightness));
                check_field("brightness_changed", 8'(head_exp.brightness_changed),
                            8'(o_brightness_changed));
                check_field("second_pulse", 8'(head_exp.second_pulse), 8'(o_second_pulse));
                check_field("flash_level", 8'(head_exp.flash_level), 8'(o_flash_level));
                check_field("scan_pulse", 8'(head_exp.scan_pulse), 8'(o_scan_pulse));
                check_field("press0_pulse", 8'(head_exp.press0_pulse), 8'(o_press0_pulse));
                check_field("long0_level", 8'(head_exp.long0_level), 8'(o_long0_level));
                check_field("press1_pulse", 8'(head_exp.press1_pulse), 8'(o_press1_pulse));
                check_field("long1_level", 8'(head_exp.long1_level), 8'(o_long1_level));
                check_field("backlight_remaining", head_exp.backlight_remaining,
                            o_backlight_remaining);
                beats_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats pending", cycle_cnt,
                     tick_results_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_ramp = RST_RAMP_PERIOD;
        cfg_sec = RST_SECOND_PERIOD;
        cfg_scan = RST_SCAN_PERIOD;
        cfg_flash = RST_FLASH_THRESHOLD;
        cfg_long = RST_LONG_PRESS_SCANS;
        cfg_bl = RST_BACKLIGHT_SECONDS;
        btn_prev[0] = 1'b1;
        btn_prev[1] = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_periods();
        test_period_lowered();
        test_register_masking();
        test_backpressure();
        test_random_settings();

        wait_results_done();
        repeat (4) @(posedge i_clk);
        $display("run: %0d ticks sent, %0d result beats checked, %0d register writes",
                 ticks_sent, beats_checked, cfg_writes);
        $display("run: %0d press pulses, %0d ticks with a long press held, %0d errors",
                 press_pulses, long_ticks, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tbrs_pkg.sv
rtl/tick_button_ramp_scheduler.sv
verif/tb_tick_button_ramp_scheduler.sv
